[rtl/jet_pkg.sv]
package jet_pkg;

    // Fixed-point format of z, c, origin and step
    localparam int FRAC_BITS  = 28;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int COORD_W    = 10;
    localparam int COUNT_W    = 10;
    localparam int STEP_W     = 31;
    localparam int REG_IDX_W  = 3;

    // Escape when |z|^2 > 4, with |z|^2 carrying 2*FRAC_BITS fraction bits
    localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(1) << (2 * FRAC_BITS + 2);

    // Register indexes of the write port
    localparam logic [REG_IDX_W-1:0] REG_LIMIT       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CONST_REAL  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CONST_IMAG  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_STEP  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BASE_COLOR  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_MASK  = 3'd7;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_R,
        ST_INIT_I,
        ST_INIT_Z,
        ST_SQ_R,
        ST_SQ_I,
        ST_CROSS,
        ST_UPDATE,
        ST_COLOR,
        ST_FINISH
    } jet_state_t;

    // Clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] max_v;
        logic signed [PROD_W-1:0] min_v;
        max_v = PROD_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
        min_v = PROD_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}));
        if (v > max_v)
            return max_v[DATA_W-1:0];
        else if (v < min_v)
            return min_v[DATA_W-1:0];
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

[rtl/julia_escape_time_pixel.sv]
// Channel  | Dir | Payload (lowest bits first)                          | Accept
// s_axis   | in  | tdata[23:0]: pixel_col[9:0], pixel_row[19:10]        | tvalid & tready
// m_axis   | out | tdata[63:0]: out_col, out_row, pixel_value,          | tvalid & tready
//          |     |              escape_count                            |
// wr       | in  | wr_index selects register, wr_data its value         | wr_en
//
// An item runs the start steps, the iteration loop (skipped for a zero limit)
// and the colour step. All products go through a single 32x32 signed multiplier,
// three per iteration, plus one for each start coordinate and one for the colour.
// Input is taken only while the sequencer is idle; a finished result sits in the
// output register, so a stalled output holds the next pixel only at its last step.
// rst_n clears the sequencer and output valid and reloads the register defaults.
module julia_escape_time_pixel
    import jet_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_col[9:0], pixel_row[19:10], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_col[9:0], out_row[19:10],
                                        // pixel_value[51:20], escape_count[61:52], zero pad
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data
);

    jet_state_t state_reg;
    jet_state_t state_next;

    // Configuration registers
    logic        [COUNT_W-1:0] limit_reg;
    logic signed [DATA_W-1:0]  cr_reg;
    logic signed [DATA_W-1:0]  ci_reg;
    logic signed [DATA_W-1:0]  origin_r_reg;
    logic signed [DATA_W-1:0]  origin_i_reg;
    logic        [STEP_W-1:0]  step_reg;
    logic        [DATA_W-1:0]  base_reg;
    logic        [DATA_W-1:0]  mask_reg;

    // Working registers
    logic        [COORD_W-1:0] col_reg;
    logic        [COORD_W-1:0] row_reg;
    logic signed [DATA_W-1:0]  zr_reg;
    logic signed [DATA_W-1:0]  zi_reg;
    logic signed [PROD_W-1:0]  rr_reg;
    logic signed [PROD_W-1:0]  ii_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic        [COUNT_W-1:0] count_reg;
    logic                      esc_reg;
    logic                      test_reg;

    // Output register
    logic                      out_valid_reg;
    logic        [COORD_W-1:0] out_col_reg;
    logic        [COORD_W-1:0] out_row_reg;
    logic        [DATA_W-1:0]  out_pix_reg;
    logic        [COUNT_W-1:0] out_cnt_reg;

    // Shared multiplier and datapath terms
    logic signed [DATA_W-1:0]  mul_a;
    logic signed [DATA_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic        [PROD_W-1:0]  mag;
    logic                      escape_hit;
    logic        [COUNT_W:0]   count_inc;
    logic                      limit_hit;
    logic signed [PROD_W-1:0]  re_diff;
    logic signed [DATA_W-1:0]  zr_new;
    logic signed [DATA_W-1:0]  zi_new;
    logic signed [DATA_W-1:0]  zr_init;
    logic signed [DATA_W-1:0]  zi_init;
    logic                      out_load;

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // |z|^2 of the freshly updated z: rr_reg holds zr^2, prod_reg holds zi^2
    assign mag        = unsigned'(rr_reg) + unsigned'(prod_reg);
    assign escape_hit = (mag > ESC_LIMIT);
    assign count_inc  = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign limit_hit  = (count_inc == {1'b0, limit_reg});

    // z*z + c with floor shifts, then clamp
    assign re_diff = rr_reg - ii_reg;
    assign zr_new  = sat32((re_diff >>> FRAC_BITS) + PROD_W'(cr_reg));
    assign zi_new  = sat32((prod_reg >>> (FRAC_BITS - 1)) + PROD_W'(ci_reg));

    // Start point: origin + coordinate * step
    assign zr_init = sat32(PROD_W'(origin_r_reg) + prod_reg);
    assign zi_init = sat32(PROD_W'(origin_i_reg) + prod_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_load      = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_cnt_reg, out_pix_reg, out_row_reg, out_col_reg};

    // Select multiplier operands and next state
    always_comb
    begin
        state_next = state_reg;
        mul_a      = signed'(~mask_reg);
        mul_b      = signed'({{(DATA_W-COUNT_W){1'b0}}, count_reg});
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_INIT_R;
            end
            ST_INIT_R:
            begin
                mul_a      = signed'({{(DATA_W-COORD_W){1'b0}}, col_reg});
                mul_b      = signed'({1'b0, step_reg});
                state_next = ST_INIT_I;
            end
            ST_INIT_I:
            begin
                mul_a      = signed'({{(DATA_W-COORD_W){1'b0}}, row_reg});
                mul_b      = signed'({1'b0, step_reg});
                state_next = ST_INIT_Z;
            end
            ST_INIT_Z:
            begin
                if (limit_reg == '0)
                    state_next = ST_COLOR;
                else
                    state_next = ST_SQ_R;
            end
            ST_SQ_R:
            begin
                mul_a      = zr_reg;
                mul_b      = zr_reg;
                state_next = ST_SQ_I;
            end
            ST_SQ_I:
            begin
                mul_a      = zi_reg;
                mul_b      = zi_reg;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
                if (test_reg && (escape_hit || limit_hit))
                    state_next = ST_COLOR;
                else
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_SQ_R;
            end
            ST_COLOR:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state, loop control and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            esc_reg       <= 1'b0;
            test_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Start a pixel clean
            if (state_reg == ST_IDLE)
            begin
                count_reg <= '0;
                esc_reg   <= 1'b0;
                test_reg  <= 1'b0;
            end
            // Test the updated z, advance the count when it stays bounded
            if (state_reg == ST_CROSS && test_reg)
            begin
                if (escape_hit)
                    esc_reg <= 1'b1;
                else
                    count_reg <= count_inc[COUNT_W-1:0];
            end
            if (state_reg == ST_UPDATE)
                test_reg <= 1'b1;
            // Hold the result until taken
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= COUNT_W'(100);
            cr_reg       <= DATA_W'(76504105);
            ci_reg       <= DATA_W'(2684355);
            origin_r_reg <= DATA_W'(-429496730);
            origin_i_reg <= DATA_W'(-483183821);
            step_reg     <= STEP_W'(766958);
            base_reg     <= DATA_W'(32'h00FF_FFFF);
            mask_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_LIMIT:       limit_reg    <= wr_data[COUNT_W-1:0];
                REG_CONST_REAL:  cr_reg       <= signed'(wr_data);
                REG_CONST_IMAG:  ci_reg       <= signed'(wr_data);
                REG_ORIGIN_REAL: origin_r_reg <= signed'(wr_data);
                REG_ORIGIN_IMAG: origin_i_reg <= signed'(wr_data);
                REG_PIXEL_STEP:  step_reg     <= wr_data[STEP_W-1:0];
                REG_BASE_COLOR:  base_reg     <= wr_data;
                REG_COLOR_MASK:  mask_reg     <= wr_data;
                default:         limit_reg    <= limit_reg;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            col_reg <= s_axis_tdata[COORD_W-1:0];
            row_reg <= s_axis_tdata[2*COORD_W-1:COORD_W];
        end
        if (state_reg == ST_INIT_I)
            zr_reg <= zr_init;
        if (state_reg == ST_INIT_Z)
            zi_reg <= zi_init;
        if (state_reg == ST_SQ_I)
            rr_reg <= prod_reg;
        if (state_reg == ST_CROSS)
            ii_reg <= prod_reg;
        if (state_reg == ST_UPDATE)
        begin
            zr_reg <= zr_new;
            zi_reg <= zi_new;
        end
        // Load the result: prod_reg holds (~mask) * count here
        if (out_load)
        begin
            out_col_reg <= col_reg;
            out_row_reg <= row_reg;
            out_pix_reg <= esc_reg ? (base_reg & prod_reg[DATA_W-1:0]) : '0;
            out_cnt_reg <= count_reg;
        end
    end

endmodule
